// ----- hw/rtl/modbus_rtu_master_transaction_defines.svh -----
// Assertion macros for the Modbus RTU master checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef MODBUS_RTU_MASTER_TRANSACTION_DEFINES_SVH
`define MODBUS_RTU_MASTER_TRANSACTION_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MRM_ASSERT_NOW(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("mrm check failed");

// Next-cycle implication, disabled during reset
`define MRM_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("mrm check failed");

`endif

// ----- hw/rtl/mrm_pkg.sv -----
// Shared types, codes and the CRC-16/MODBUS byte step for the RTU master.
// No dependencies.
package mrm_pkg;

  // Input transaction commands
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_RX    = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Completion status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_WRONG   = 3'd1;
  localparam logic [2:0] ST_EXCEPT  = 3'd2;
  localparam logic [2:0] ST_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_BAD_CRC = 3'd4;

  // Configuration register indexes
  localparam logic REG_SLAVE_ADDR = 1'b0;
  localparam logic REG_TIMEOUT    = 1'b1;

  // Function codes
  localparam logic [7:0] FC_READ_COILS  = 8'd1;
  localparam logic [7:0] FC_READ_DISC   = 8'd2;
  localparam logic [7:0] FC_READ_HOLD   = 8'd3;
  localparam logic [7:0] FC_READ_INPUT  = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
  localparam logic [7:0] FC_WRITE_REG   = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS  = 8'd16;
  localparam logic [7:0] FC_MASK_WRITE  = 8'd22;
  localparam logic [7:0] FC_READ_WRITE  = 8'd23;

  localparam logic [7:0]  FC_MASK     = 8'h7F;
  localparam logic [15:0] COIL_ON     = 16'hFF00;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam int          STORE_DEPTH = 16;

  typedef enum logic [2:0] {
    S_IDLE, S_TX, S_EVAL, S_WORDS, S_STATUS
  } ctl_state_t;

  typedef enum logic [3:0] {
    PH_ADDR, PH_FC, PH_RA_H, PH_RA_L, PH_RQ_H, PH_RQ_L, PH_WA_H, PH_WA_L,
    PH_V_H, PH_V_L, PH_WQ_H, PH_WQ_L, PH_BC, PH_DATA, PH_CRC_L, PH_CRC_H
  } tx_phase_t;

  typedef enum logic [1:0] { EV_NONE, EV_BYTE, EV_TICK } ev_kind_t;

  // Controller to datapath
  typedef struct packed {
    logic do_load;
    logic do_start;
    logic do_rx;
    logic do_tick;
    logic emit_tx;
    logic emit_word;
    logic emit_status;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic tx_last;
    logic ev_fire;
    logic ev_words;
    logic word_last;
  } dp_stat_t;

  function automatic logic is_read_fc(logic [7:0] fc);
    return fc inside {FC_READ_COILS, FC_READ_DISC, FC_READ_HOLD, FC_READ_INPUT,
                      FC_READ_WRITE};
  endfunction

  function automatic logic is_write_fc(logic [7:0] fc);
    return fc inside {FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS,
                      FC_MASK_WRITE, FC_READ_WRITE};
  endfunction

  // One byte of CRC-16/MODBUS, LSB first
  function automatic logic [15:0] crc16_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/mrm_datapath.sv -----
// Datapath of the RTU master: word stores, frame byte sequencer, receive
// parser, timeout counter and output register. Depends on mrm_pkg.
module mrm_datapath
  import mrm_pkg::*;
#(
  parameter int MAX_BUFFER_WORDS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_cmd_t    cmd,
  output dp_stat_t    stat,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic [3:0]  in_word_index,
  input  logic [15:0] in_word_value,
  input  logic [7:0]  in_function_code,
  input  logic [15:0] in_read_address,
  input  logic [15:0] in_read_quantity,
  input  logic [15:0] in_write_address,
  input  logic [15:0] in_write_quantity,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_tx_byte,
  output logic [3:0]  out_word_index_res,
  output logic [15:0] out_word_value_res,
  output logic [2:0]  out_status,
  output logic [7:0]  out_exception_code,
  output logic        out_last
);

  localparam int WORD_CAP = (MAX_BUFFER_WORDS < STORE_DEPTH) ? MAX_BUFFER_WORDS
                                                             : STORE_DEPTH;
  localparam logic [13:0] COIL_CAP = 14'(2 * WORD_CAP);
  localparam logic [15:0] REG_CAP  = 16'(WORD_CAP);
  localparam logic [7:0]  CAP8     = 8'(WORD_CAP);
  localparam logic [8:0]  CAP9     = 9'(WORD_CAP);

  // Configuration
  logic [7:0]  slave_addr_r;
  logic [15:0] timeout_r;

  // Stores
  logic [15:0] tx_words_r [STORE_DEPTH];
  logic [7:0]  rx_hi_r    [STORE_DEPTH];
  logic [7:0]  rx_lo_r    [STORE_DEPTH];

  // Request frame
  tx_phase_t   phase_r, phase_nxt;
  logic [7:0]  fc_r;
  logic [15:0] ra_r, rq_r, wa_r, wq_r;
  logic        coil_on_r, coil_r;
  logic [5:0]  nb_r, idx_r;
  logic [15:0] crc_tx_r;
  logic [7:0]  tx_byte;

  // Response state
  logic        busy_r;
  logic [7:0]  pend_fc_r, resp_fc_r, rx_count_r, bytes_left_r, byte_count_r;
  logic [15:0] crc_rx_r;
  logic [7:0]  dly0_r, dly1_r;
  logic [15:0] elapsed_r;
  logic        pos4_r, to_flag_r;
  ev_kind_t    ev_r;
  logic [4:0]  wc_r;

  // Evaluation
  logic [2:0]  ev_status;
  logic [7:0]  ev_exc;
  logic [4:0]  nw;

  // Output register
  logic        out_valid_r;
  logic        out_free;

  assign out_free = !out_valid_r || !out_stall;

  // Frame byte select and next phase
  always_comb begin
    logic [15:0] w;
    logic        lane_hi;
    w       = tx_words_r[idx_r[4:1]];
    lane_hi = coil_r ? idx_r[0] : !idx_r[0];
    tx_byte   = 8'h00;
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_ADDR: begin
        tx_byte   = slave_addr_r;
        phase_nxt = PH_FC;
      end
      PH_FC: begin
        tx_byte   = fc_r;
        phase_nxt = is_read_fc(fc_r) ? PH_RA_H : (is_write_fc(fc_r) ? PH_WA_H : PH_CRC_L);
      end
      PH_RA_H: begin tx_byte = ra_r[15:8]; phase_nxt = PH_RA_L; end
      PH_RA_L: begin tx_byte = ra_r[7:0];  phase_nxt = PH_RQ_H; end
      PH_RQ_H: begin tx_byte = rq_r[15:8]; phase_nxt = PH_RQ_L; end
      PH_RQ_L: begin
        tx_byte   = rq_r[7:0];
        phase_nxt = is_write_fc(fc_r) ? PH_WA_H : PH_CRC_L;
      end
      PH_WA_H: begin tx_byte = wa_r[15:8]; phase_nxt = PH_WA_L; end
      PH_WA_L: begin
        tx_byte = wa_r[7:0];
        if (fc_r == FC_WRITE_COIL) begin
          phase_nxt = PH_V_H;
        end else if (fc_r == FC_WRITE_REG || fc_r == FC_MASK_WRITE) begin
          phase_nxt = PH_DATA;
        end else begin
          phase_nxt = PH_WQ_H;
        end
      end
      PH_V_H: begin
        tx_byte   = coil_on_r ? COIL_ON[15:8] : 8'h00;
        phase_nxt = PH_V_L;
      end
      PH_V_L: begin
        tx_byte   = coil_on_r ? COIL_ON[7:0] : 8'h00;
        phase_nxt = PH_CRC_L;
      end
      PH_WQ_H: begin tx_byte = wq_r[15:8]; phase_nxt = PH_WQ_L; end
      PH_WQ_L: begin tx_byte = wq_r[7:0];  phase_nxt = PH_BC; end
      PH_BC: begin
        tx_byte   = {2'b00, nb_r};
        phase_nxt = (nb_r == 6'd0) ? PH_CRC_L : PH_DATA;
      end
      PH_DATA: begin
        tx_byte   = lane_hi ? w[15:8] : w[7:0];
        phase_nxt = (idx_r == nb_r - 6'd1) ? PH_CRC_L : PH_DATA;
      end
      PH_CRC_L: begin tx_byte = crc_tx_r[7:0];  phase_nxt = PH_CRC_H; end
      PH_CRC_H: begin tx_byte = crc_tx_r[15:8]; phase_nxt = PH_ADDR; end
      default: begin tx_byte = 8'h00; phase_nxt = PH_ADDR; end
    endcase
  end

  // Evaluate the last received byte or tick
  always_comb begin
    logic [8:0] half;
    ev_status = ST_OK;
    ev_exc    = 8'h00;
    stat.ev_fire = 1'b0;
    half = (pend_fc_r == FC_READ_COILS || pend_fc_r == FC_READ_DISC)
         ? ({1'b0, byte_count_r} + 9'd1) >> 1
         : (pend_fc_r == FC_READ_HOLD || pend_fc_r == FC_READ_INPUT ||
            pend_fc_r == FC_READ_WRITE) ? {2'b00, byte_count_r[7:1]} : 9'd0;
    nw = (half > CAP9) ? 5'(WORD_CAP) : half[4:0];
    case (ev_r)
      EV_TICK: begin
        stat.ev_fire = to_flag_r;
        ev_status    = ST_TIMEOUT;
      end
      EV_BYTE: begin
        if (pos4_r && ((resp_fc_r & FC_MASK) != pend_fc_r)) begin
          stat.ev_fire = 1'b1;
          ev_status    = ST_WRONG;
        end else if (pos4_r && resp_fc_r[7]) begin
          stat.ev_fire = 1'b1;
          ev_status    = ST_EXCEPT;
          ev_exc       = byte_count_r;
        end else if (bytes_left_r == 8'd0) begin
          stat.ev_fire = 1'b1;
          ev_status = (crc_rx_r[7:0] != dly0_r || crc_rx_r[15:8] != dly1_r)
                    ? ST_BAD_CRC : ST_OK;
        end
      end
      default: stat.ev_fire = 1'b0;
    endcase
    stat.ev_words  = (ev_status == ST_OK) && (nw != 5'd0);
    stat.word_last = (wc_r == nw - 5'd1);
    stat.tx_last   = (phase_r == PH_CRC_H);
    stat.out_free  = out_free;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= 8'd1;
      timeout_r    <= 16'd2000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SLAVE_ADDR: slave_addr_r <= cfg_wdata[7:0];
        REG_TIMEOUT:    timeout_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Transmit word store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORE_DEPTH; i++) tx_words_r[i] <= 16'h0000;
    end else if (cmd.do_load && (int'(in_word_index) < MAX_BUFFER_WORDS)) begin
      tx_words_r[in_word_index] <= in_word_value;
    end
  end

  // Latch a request and step the frame sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_ADDR;
      idx_r    <= 6'd0;
      crc_tx_r <= CRC_INIT;
    end else if (cmd.do_start) begin
      phase_r  <= PH_ADDR;
      idx_r    <= 6'd0;
      crc_tx_r <= CRC_INIT;
    end else if (cmd.emit_tx) begin
      phase_r <= phase_nxt;
      if (phase_r == PH_DATA) idx_r <= idx_r + 6'd1;
      if (phase_r != PH_CRC_L && phase_r != PH_CRC_H) begin
        crc_tx_r <= crc16_feed(crc_tx_r, tx_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [13:0] coil_n;
    logic [15:0] reg_n;
    coil_n = 14'(({1'b0, in_write_quantity} + 17'd7) >> 3);
    reg_n  = (in_write_quantity < REG_CAP) ? in_write_quantity : REG_CAP;
    if (cmd.do_start) begin
      fc_r      <= in_function_code;
      ra_r      <= in_read_address;
      rq_r      <= in_read_quantity;
      wa_r      <= in_write_address;
      wq_r      <= in_write_quantity;
      coil_on_r <= (in_write_quantity != 16'd0);
      coil_r    <= (in_function_code == FC_WRITE_COILS);
      case (in_function_code)
        FC_WRITE_REG:   nb_r <= 6'd2;
        FC_MASK_WRITE:  nb_r <= 6'd4;
        FC_WRITE_COILS: nb_r <= (coil_n > COIL_CAP) ? COIL_CAP[5:0] : coil_n[5:0];
        FC_WRITE_REGS, FC_READ_WRITE: nb_r <= {reg_n[4:0], 1'b0};
        default:        nb_r <= 6'd0;
      endcase
    end
  end

  // Receive parser, timeout counter and transaction state
  always_ff @(posedge clk) begin
    logic [7:0]  pos, j, bl_dec;
    logic [16:0] n;
    logic        take, hi;
    pos    = rx_count_r;
    j      = pos - 8'd3;
    bl_dec = (bytes_left_r != 8'd0) ? bytes_left_r - 8'd1 : 8'd0;
    n      = {1'b0, elapsed_r} + 17'd1;
    take   = busy_r && !(rx_count_r == 8'd0 && in_rx_byte != slave_addr_r);
    hi     = (pend_fc_r == FC_READ_COILS || pend_fc_r == FC_READ_DISC) ? j[0] : !j[0];
    if (!rst_n) begin
      busy_r       <= 1'b0;
      pend_fc_r    <= 8'd0;
      resp_fc_r    <= 8'd0;
      rx_count_r   <= 8'd0;
      bytes_left_r <= 8'd8;
      byte_count_r <= 8'd0;
      crc_rx_r     <= CRC_INIT;
      dly0_r       <= 8'd0;
      dly1_r       <= 8'd0;
      elapsed_r    <= 16'd0;
      pos4_r       <= 1'b0;
      to_flag_r    <= 1'b0;
      ev_r         <= EV_NONE;
      wc_r         <= 5'd0;
    end else if (cmd.do_start) begin
      busy_r       <= 1'b1;
      pend_fc_r    <= in_function_code;
      resp_fc_r    <= 8'd0;
      rx_count_r   <= 8'd0;
      bytes_left_r <= 8'd8;
      byte_count_r <= 8'd0;
      crc_rx_r     <= CRC_INIT;
      dly0_r       <= 8'd0;
      dly1_r       <= 8'd0;
      elapsed_r    <= 16'd0;
    end else if (cmd.do_rx) begin
      wc_r <= 5'd0;
      ev_r <= take ? EV_BYTE : EV_NONE;
      pos4_r <= (pos == 8'd4);
      if (take) begin
        if (rx_count_r != 8'hFF) rx_count_r <= rx_count_r + 8'd1;
        if (pos >= 8'd2) crc_rx_r <= crc16_feed(crc_rx_r, dly0_r);
        dly0_r <= dly1_r;
        dly1_r <= in_rx_byte;
        if (pos == 8'd1) resp_fc_r <= in_rx_byte;
        if (pos == 8'd2) byte_count_r <= in_rx_byte;
        if (pos >= 8'd3 && j < byte_count_r && {1'b0, j[7:1]} < CAP8) begin
          if (!j[0]) begin
            rx_hi_r[j[4:1]] <= hi ? in_rx_byte : 8'h00;
            rx_lo_r[j[4:1]] <= hi ? 8'h00 : in_rx_byte;
          end else if (hi) begin
            rx_hi_r[j[4:1]] <= in_rx_byte;
          end else begin
            rx_lo_r[j[4:1]] <= in_rx_byte;
          end
        end
        bytes_left_r <= bl_dec;
        if (pos == 8'd4) begin
          if (is_read_fc(pend_fc_r)) begin
            bytes_left_r <= byte_count_r;
          end else if (pend_fc_r == FC_WRITE_COIL || pend_fc_r == FC_WRITE_REG ||
                       pend_fc_r == FC_WRITE_COILS || pend_fc_r == FC_WRITE_REGS) begin
            bytes_left_r <= 8'd3;
          end else if (pend_fc_r == FC_MASK_WRITE) begin
            bytes_left_r <= 8'd5;
          end
        end
      end
    end else if (cmd.do_tick) begin
      ev_r      <= busy_r ? EV_TICK : EV_NONE;
      to_flag_r <= (n > {1'b0, timeout_r});
      if (busy_r) elapsed_r <= n[16] ? 16'hFFFF : n[15:0];
    end else if (cmd.emit_word) begin
      wc_r <= wc_r + 5'd1;
    end else if (cmd.emit_status) begin
      busy_r <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_tx || cmd.emit_word || cmd.emit_status) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_tx || cmd.emit_word || cmd.emit_status) begin
      out_tx_byte        <= 8'h00;
      out_word_index_res <= 4'd0;
      out_word_value_res <= 16'h0000;
      out_status         <= ST_OK;
      out_exception_code <= 8'h00;
      if (cmd.emit_tx) begin
        out_kind    <= KIND_TX;
        out_tx_byte <= tx_byte;
        out_last    <= (phase_r == PH_CRC_H);
      end else if (cmd.emit_word) begin
        out_kind           <= KIND_WORD;
        out_word_index_res <= wc_r[3:0];
        out_word_value_res <= {rx_hi_r[wc_r[3:0]], rx_lo_r[wc_r[3:0]]};
        out_last           <= 1'b0;
      end else begin
        out_kind           <= KIND_STATUS;
        out_status         <= ev_status;
        out_exception_code <= ev_exc;
        out_last           <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/mrm_controller.sv -----
// Controller state machine of the RTU master: accepts transactions and
// sequences frame, word and status emission. Depends on mrm_pkg.
module mrm_controller
  import mrm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  dp_stat_t   stat,
  output ctl_cmd_t   cmd
);

  ctl_state_t state_r, state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            CMD_LOAD:  cmd.do_load = 1'b1;
            CMD_START: begin
              cmd.do_start = 1'b1;
              state_nxt    = S_TX;
            end
            CMD_RX: begin
              cmd.do_rx = 1'b1;
              state_nxt = S_EVAL;
            end
            CMD_TICK: begin
              cmd.do_tick = 1'b1;
              state_nxt   = S_EVAL;
            end
            default: ;
          endcase
        end
      end
      S_TX: begin
        if (stat.out_free) begin
          cmd.emit_tx = 1'b1;
          if (stat.tx_last) state_nxt = S_IDLE;
        end
      end
      S_EVAL: begin
        if (!stat.ev_fire) begin
          state_nxt = S_IDLE;
        end else if (stat.ev_words) begin
          state_nxt = S_WORDS;
        end else begin
          state_nxt = S_STATUS;
        end
      end
      S_WORDS: begin
        if (stat.out_free) begin
          cmd.emit_word = 1'b1;
          if (stat.word_last) state_nxt = S_STATUS;
        end
      end
      S_STATUS: begin
        if (stat.out_free) begin
          cmd.emit_status = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/modbus_rtu_master_transaction.sv -----
// Modbus RTU master transaction engine, top level.
// Instantiates mrm_controller and mrm_datapath; depends on mrm_pkg.
//
// A load-word transaction writes a transmit store word. A start
// transaction latches the request and then emits the request frame
// (4 to 45 bytes) through the output register, one byte per cycle while
// the output is not stalled. A received byte or a tick is accepted, then
// evaluated, and then emits the results it causes: up to MAX_BUFFER_WORDS
// (at most 16) response words and one status. Received bytes feed the CRC
// one at a time, and a new byte is taken only when the controller is idle.
module modbus_rtu_master_transaction
  import mrm_pkg::*;
#(
  parameter int MAX_BUFFER_WORDS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [3:0]  in_word_index,
  input  logic [15:0] in_word_value,
  input  logic [7:0]  in_function_code,
  input  logic [15:0] in_read_address,
  input  logic [15:0] in_read_quantity,
  input  logic [15:0] in_write_address,
  input  logic [15:0] in_write_quantity,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_tx_byte,
  output logic [3:0]  out_word_index_res,
  output logic [15:0] out_word_value_res,
  output logic [2:0]  out_status,
  output logic [7:0]  out_exception_code,
  output logic        out_last
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Sequence transactions
  mrm_controller u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_cmd   (in_cmd),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold stores, build frames, parse responses
  mrm_datapath #(
    .MAX_BUFFER_WORDS (MAX_BUFFER_WORDS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_word_index      (in_word_index),
    .in_word_value      (in_word_value),
    .in_function_code   (in_function_code),
    .in_read_address    (in_read_address),
    .in_read_quantity   (in_read_quantity),
    .in_write_address   (in_write_address),
    .in_write_quantity  (in_write_quantity),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_tx_byte        (out_tx_byte),
    .out_word_index_res (out_word_index_res),
    .out_word_value_res (out_word_value_res),
    .out_status         (out_status),
    .out_exception_code (out_exception_code),
    .out_last           (out_last)
  );

endmodule

// ----- hw/rtl/mrm_checker.sv -----
// Port-level checks for the RTU master, bound to the top level.
// Depends on mrm_pkg and modbus_rtu_master_transaction_defines.svh.
`include "modbus_rtu_master_transaction_defines.svh"

module mrm_checker
  import mrm_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic       out_last,
  input logic [7:0] out_tx_byte
);

  // A status item always closes its transaction
  `MRM_ASSERT_NOW(a_status_last, out_valid && out_kind == KIND_STATUS, out_last)

  // A response word is never the final result
  `MRM_ASSERT_NOW(a_word_not_last, out_valid && out_kind == KIND_WORD, !out_last)

  // Hold a stalled result
  `MRM_ASSERT_NEXT(a_stall_hold, out_valid && out_stall,
                   out_valid && $stable(out_kind) && $stable(out_tx_byte))

endmodule

bind modbus_rtu_master_transaction mrm_checker u_mrm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_kind    (out_kind),
  .out_last    (out_last),
  .out_tx_byte (out_tx_byte)
);
